>>> hdl/rcg_pkg.sv
`timescale 1ns / 1ps

package rcg_pkg;

    localparam int HashBytesDef = 32;
    localparam int SeedBytesDef = 16;
    localparam int SeedCap      = 16;
    localparam int CodeChars    = 4;
    localparam int CfgIdxW      = 2;
    localparam int CfgDataW     = 64;
    localparam int CandW        = 32;
    localparam int ScaleMul     = 7;

    localparam logic [1:0] LastChar = 2'(CodeChars - 1);

    typedef enum logic [CfgIdxW-1:0] {
        REG_SEED_LOW  = 2'd0,
        REG_SEED_HIGH = 2'd1,
        REG_SELECTED  = 2'd2,
        REG_CONFIRM   = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    typedef struct packed {
        logic       en;
        logic       first;
        logic [7:0] data;
    } t_absorb;

    localparam logic [8*32-1:0] SymTable = "ABCDEFGHJKLMNPQRSTUVWXYZ23456789";

    function automatic logic [7:0] sym_char(input logic [4:0] idx);
        logic [4:0] pos;
        pos = 5'd31 - idx;
        return SymTable[{pos, 3'b000} +: 8];
    endfunction

endpackage

>>> hdl/rcg_hash.sv
`timescale 1ns / 1ps

module rcg_hash #(
    parameter int HASH_BYTES = rcg_pkg::HashBytesDef,
    parameter int HW         = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rcg_pkg::t_absorb i_absorb,
    input  logic [HW-1:0]    i_rd_addr,
    output logic [7:0]       o_rd_data
);
    import rcg_pkg::*;

    localparam int ScaleStep = ScaleMul % HASH_BYTES;
    localparam logic [HW:0] HashSize = (HW+1)'(HASH_BYTES);
    localparam logic [HW-1:0] HashLast = HW'(HASH_BYTES - 1);

    logic [7:0]    r_store [HASH_BYTES];
    logic [7:0]    n_store [HASH_BYTES];
    logic [HW-1:0] r_pidx;
    logic [HW-1:0] r_sidx;
    logic [HW-1:0] n_pidx;
    logic [HW-1:0] n_sidx;
    logic [HW-1:0] w_pidx;
    logic [HW-1:0] w_sidx;
    logic [HW:0]   w_ssum;

    assign w_pidx = i_absorb.first ? '0 : r_pidx;
    assign w_sidx = i_absorb.first ? '0 : r_sidx;
    assign w_ssum = {1'b0, w_sidx} + (HW+1)'(ScaleStep);

    always_comb begin
        logic [7:0] base;
        logic [7:0] xv;
        for (int e = 0; e < HASH_BYTES; e++) begin
            base = i_absorb.first ? 8'd0 : r_store[e];
            xv   = (HW'(e) == w_pidx) ? (base ^ i_absorb.data) : base;
            n_store[e] = i_absorb.en ?
                ((HW'(e) == w_sidx) ? (xv + i_absorb.data) : xv) : r_store[e];
        end
        n_pidx = (w_pidx == HashLast) ? '0 : w_pidx + HW'(1);
        n_sidx = (w_ssum >= HashSize) ? HW'(w_ssum - HashSize) : w_ssum[HW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < HASH_BYTES; e++) begin
                r_store[e] <= '0;
            end
            r_pidx <= '0;
            r_sidx <= '0;
        end else begin
            r_store <= n_store;
            if (i_absorb.en) begin
                r_pidx <= n_pidx;
                r_sidx <= n_sidx;
            end
        end
    end

    assign o_rd_data = r_store[i_rd_addr];

endmodule

>>> hdl/rcg_mix.sv
`timescale 1ns / 1ps

module rcg_mix #(
    parameter int HW = 5
) (
    input  logic [31:0] i_v,
    input  logic [7:0]  i_hash_byte,
    input  logic [HW:0] i_weight,
    input  logic [7:0]  i_seed_byte,
    output logic [31:0] o_v
);
    import rcg_pkg::*;

    logic [HW+8:0] w_prod;
    logic [31:0]   w_sum;
    logic [31:0]   w_x3;

    assign w_prod = (HW+9)'(i_hash_byte) * (HW+9)'(i_weight);
    assign w_sum  = i_v + 32'(w_prod) + 32'(i_seed_byte);
    assign w_x3   = w_sum ^ (w_sum << 3);
    assign o_v    = w_x3 ^ (w_x3 >> 2);

endmodule

>>> hdl/receipt_code_generator.sv
`timescale 1ns / 1ps
// absorb beat: folded into the hash store, absorb beats can follow back to back
// derived query: one hash byte per cycle through the shared mix step, for each code
//   char in turn, and then the output load; no beat is taken until that load
// confirm query: goes straight to the done state and the output load, no mix steps
// a held output beat stalls a finished query; no beat taken meanwhile
// synchronous active-low reset clears hash, indices, config and control

module receipt_code_generator #(
    parameter int HASH_BYTES = rcg_pkg::HashBytesDef,
    parameter int SEED_BYTES = rcg_pkg::SeedBytesDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [rcg_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [rcg_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // data_byte[7:0], cand_id[39:8]
    input  logic [39:0]                  s_axis_tdata,
    // op[0], first[1]
    input  logic [1:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // candidate_out[31:0], code_char0[39:32], code_char1[47:40],
    // code_char2[55:48], code_char3[63:56]
    output logic [63:0]                  m_axis_tdata,
    // is_confirm[0]
    output logic                         m_axis_tuser
);
    import rcg_pkg::*;

    localparam int HW = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;
    localparam int SW = (SEED_BYTES > 1) ? $clog2(SEED_BYTES) : 1;
    localparam logic [HW-1:0] HashLast = HW'(HASH_BYTES - 1);
    localparam logic [SW-1:0] SeedLast = SW'(SEED_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state        r_state;
    logic [63:0]   r_seed_low;
    logic [63:0]   r_seed_high;
    logic [31:0]   r_selected;
    logic [31:0]   r_confirm;
    logic [31:0]   r_cand;
    logic [31:0]   r_v;
    logic [1:0]    r_k;
    logic [SW-1:0] r_ks;
    logic [SW-1:0] r_sp;
    logic [HW-1:0] r_j;
    logic [7:0]    r_chars [CodeChars];
    logic          r_is_confirm;
    logic          r_m_valid;
    logic [63:0]   r_m_data;
    logic          r_m_user;

    logic          w_accept;
    logic [31:0]   w_in_cand;
    t_absorb       w_absorb;
    logic [7:0]    w_hash_byte;
    logic [7:0]    w_seed_bytes [SeedCap];
    logic [7:0]    w_seed_byte;
    logic [31:0]   w_mix;
    logic [HW:0]   w_weight;
    logic [SW-1:0] w_sp_inc;
    logic [SW-1:0] w_ks_inc;
    logic [1:0]    w_k_next;
    logic [31:0]   w_base_next;
    logic          w_out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_cand     = s_axis_tdata[39:8];

    assign w_absorb.en    = w_accept && (t_op'(s_axis_tuser[0]) == OP_ABSORB);
    assign w_absorb.first = s_axis_tuser[1];
    assign w_absorb.data  = s_axis_tdata[7:0];

    always_comb begin
        for (int b = 0; b < SeedCap; b++) begin
            w_seed_bytes[b] = (b < 8) ? r_seed_low[8*(b%8) +: 8] : r_seed_high[8*(b%8) +: 8];
        end
    end

    assign w_seed_byte = w_seed_bytes[4'(r_sp)];
    assign w_weight    = (HW+1)'(r_j) + (HW+1)'(1);
    assign w_sp_inc    = (r_sp == SeedLast) ? '0 : r_sp + SW'(1);
    assign w_ks_inc    = (r_ks == SeedLast) ? '0 : r_ks + SW'(1);
    assign w_k_next    = r_k + 2'd1;
    assign w_base_next = ((r_cand << 5) - r_cand) + 32'({w_k_next, 4'b0000})
                       + 32'(w_k_next);
    assign w_out_load  = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    rcg_hash #(
        .HASH_BYTES (HASH_BYTES),
        .HW         (HW)
    ) u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_absorb  (w_absorb),
        .i_rd_addr (r_j),
        .o_rd_data (w_hash_byte)
    );

    rcg_mix #(
        .HW (HW)
    ) u_mix (
        .i_v         (r_v),
        .i_hash_byte (w_hash_byte),
        .i_weight    (w_weight),
        .i_seed_byte (w_seed_byte),
        .o_v         (w_mix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_low  <= '0;
            r_seed_high <= '0;
            r_selected  <= '0;
            r_confirm   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SEED_LOW:  r_seed_low  <= i_cfg_data;
                REG_SEED_HIGH: r_seed_high <= i_cfg_data;
                REG_SELECTED:  r_selected  <= i_cfg_data[31:0];
                REG_CONFIRM:   r_confirm   <= i_cfg_data[31:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (t_op'(s_axis_tuser[0]) == OP_QUERY)) begin
                        r_cand <= w_in_cand;
                        r_v    <= (w_in_cand << 5) - w_in_cand;
                        r_k    <= '0;
                        r_ks   <= '0;
                        r_sp   <= '0;
                        r_j    <= '0;
                        if (w_in_cand == r_selected) begin
                            for (int c = 0; c < CodeChars; c++) begin
                                r_chars[c] <= r_confirm[8*c +: 8];
                            end
                            r_is_confirm <= 1'b1;
                            r_state      <= ST_DONE;
                        end else begin
                            r_is_confirm <= 1'b0;
                            r_state      <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (r_j == HashLast) begin
                        r_chars[r_k] <= sym_char(w_mix[4:0]);
                        r_j          <= '0;
                        if (r_k == LastChar) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_k  <= w_k_next;
                            r_ks <= w_ks_inc;
                            r_sp <= w_ks_inc;
                            r_v  <= w_base_next;
                        end
                    end else begin
                        r_v  <= w_mix;
                        r_j  <= r_j + HW'(1);
                        r_sp <= w_sp_inc;
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_m_data <= {r_chars[3], r_chars[2], r_chars[1], r_chars[0], r_cand};
                        r_m_user <= r_is_confirm;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_op'(s_axis_tuser[0]) == OP_QUERY)) |=> !s_axis_tready)
        else $error("query beat did not hold off input");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_j == HashLast && r_k == LastChar) |=> (r_state == ST_DONE))
        else $error("last mix step did not finish the query");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_DONE))
        else $error("output beat raised outside done state");
`endif

endmodule
